// ===== rtl/ecc_pkg.sv =====
// escape count color mapper: shared types and constants
// no dependencies; imported by every module of the block
`default_nettype none

package ecc_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int SHADE_BITS_DEF = 8;

  localparam int CFG_ADDR_BITS  = 5;
  localparam int CFG_DATA_BITS  = 32;
  localparam int SHADE_REG_BITS = 9;
  localparam int ORDER_BITS     = 3;

  localparam logic [SHADE_REG_BITS-1:0] SHADES_RESET   = 9'd8;
  localparam int                        MAX_ITER_RESET = 255;

  typedef enum logic [2:0] {
    REG_TABLE_KIND    = 3'd0,
    REG_REVERSE_ORDER = 3'd1,
    REG_CHANNEL_ORDER = 3'd2,
    REG_SHADES        = 3'd3,
    REG_MAX_ITER      = 3'd4
  } cfg_reg_e;

  typedef enum logic [ORDER_BITS-1:0] {
    ORD_RGB = 3'd0,
    ORD_RBG = 3'd1,
    ORD_GRB = 3'd2,
    ORD_GBR = 3'd3,
    ORD_BRG = 3'd4,
    ORD_BGR = 3'd5
  } ord_e;

  typedef struct packed {
    logic kind;
    logic rev;
    ord_e ord;
  } pal_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/escape_count_color_mapper.sv =====
// escape count color mapper: top level with config registers and the cell rows
// uses ecc_pkg, ecc_mul_cell, ecc_div_cell, ecc_color_cell
`default_nettype none

// Takes one iteration count per cycle while in_ready_o is high and returns one RGB
// word per count, in order. Each word runs down a row of registered cells: a
// multiply cell, then one restoring division cell per quotient bit, then the
// color cell that holds the output register. The digit permutation palette
// passes three multiply cells, with SHADE_BITS division cells per color digit;
// the smooth ramp passes SHADE_BITS+3 cells for the color index and three for
// the ramp segment. A stalled output only holds the cells that are full, so
// words keep entering while bubbles remain. Change table_kind only while no
// word is in flight.
module escape_count_color_mapper
  import ecc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int SHADE_BITS = SHADE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [COUNT_BITS-1:0]    iteration_count_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o
);

  localparam int CB  = COUNT_BITS;
  localparam int SB  = SHADE_BITS;
  localparam int PW  = CB + SB + 1;
  localparam int PTW = 1 + 2 * SB;
  localparam int QB  = SB + 3;
  localparam int SPW = CB + QB;
  localparam logic [SHADE_REG_BITS-1:0] SHADE_HI = SHADE_REG_BITS'(1 << SB);

  // config registers
  logic                      table_kind_q;
  logic                      reverse_order_q;
  logic [ORDER_BITS-1:0]     channel_order_q;
  logic [SHADE_REG_BITS-1:0] shades_q;
  logic [CB-1:0]             max_iter_q;
  cfg_reg_e                  reg_idx;
  logic                      cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[CFG_ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_kind_q    <= 1'b1;
      reverse_order_q <= 1'b0;
      channel_order_q <= ORD_RGB;
      shades_q        <= SHADES_RESET;
      max_iter_q      <= CB'(MAX_ITER_RESET);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TABLE_KIND:    table_kind_q    <= pwdata[0];
        REG_REVERSE_ORDER: reverse_order_q <= pwdata[0];
        REG_CHANNEL_ORDER: channel_order_q <= pwdata[ORDER_BITS-1:0];
        REG_SHADES:        shades_q        <= pwdata[SHADE_REG_BITS-1:0];
        REG_MAX_ITER:      max_iter_q      <= pwdata[CB-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TABLE_KIND:    prdata = CFG_DATA_BITS'(table_kind_q);
      REG_REVERSE_ORDER: prdata = CFG_DATA_BITS'(reverse_order_q);
      REG_CHANNEL_ORDER: prdata = CFG_DATA_BITS'(channel_order_q);
      REG_SHADES:        prdata = CFG_DATA_BITS'(shades_q);
      REG_MAX_ITER:      prdata = CFG_DATA_BITS'(max_iter_q);
      default:           prdata = '0;
    endcase
  end

  // derived palette settings
  pal_cfg_t                  cfg;
  logic [SHADE_REG_BITS-1:0] s_sat;
  logic [SB:0]               s_num;
  logic [SB-1:0]             s_max;
  logic [QB-1:0]             ramp_len;
  logic [QB-1:0]             ramp_last;
  logic                      in_black;

  assign cfg = '{kind: table_kind_q, rev: reverse_order_q, ord: ord_e'(channel_order_q)};

  always_comb begin
    if (shades_q < SHADE_REG_BITS'(2)) begin
      s_sat = SHADE_REG_BITS'(2);
    end else if (shades_q > SHADE_HI) begin
      s_sat = SHADE_HI;
    end else begin
      s_sat = shades_q;
    end
  end

  assign s_num     = s_sat[SB:0];
  assign s_max     = SB'(s_num - (SB+1)'(1));
  assign ramp_len  = QB'(s_max) * QB'(7) + QB'(1);
  assign ramp_last = QB'(s_max) * QB'(7);
  assign in_black  = !(iteration_count_i < max_iter_q);

  // digit permutation row: three digit groups, each multiply then SB cells
  logic           pm_in_valid;
  logic           mul_v   [3];
  logic           mul_rdy [3];
  logic [CB-1:0]  mul_a   [3];
  logic [PTW-1:0] mul_tag [3];
  logic [PW-1:0]  mul_p   [3];
  logic [PTW-1:0] mul_tago[3];
  logic           pm_v    [3][SB+1];
  logic           pm_r    [3][SB+1];
  logic [CB-1:0]  pm_rem  [3][SB+1];
  logic [SB-1:0]  pm_num  [3][SB+1];
  logic [SB-1:0]  pm_quo  [3][SB+1];
  logic [PTW-1:0] pm_tag  [3][SB+1];

  assign pm_in_valid = in_valid_i && !table_kind_q;

  for (genvar g = 0; g < 3; g++) begin : g_grp
    if (g == 0) begin : g_first
      assign mul_v[g]   = pm_in_valid;
      assign mul_a[g]   = iteration_count_i;
      assign mul_tag[g] = {in_black, {(2*SB){1'b0}}};
    end else if (g == 1) begin : g_mid
      assign mul_v[g]      = pm_v[g-1][SB];
      assign pm_r[g-1][SB] = mul_rdy[g];
      assign mul_a[g]      = pm_rem[g-1][SB];
      assign mul_tag[g]    = {pm_tag[g-1][SB][PTW-1], pm_quo[g-1][SB], {SB{1'b0}}};
    end else begin : g_last
      assign mul_v[g]      = pm_v[g-1][SB];
      assign pm_r[g-1][SB] = mul_rdy[g];
      assign mul_a[g]      = pm_rem[g-1][SB];
      assign mul_tag[g]    = {pm_tag[g-1][SB][PTW-1:SB], pm_quo[g-1][SB]};
    end

    ecc_mul_cell #(
      .AW (CB),
      .BW (SB + 1),
      .TW (PTW)
    ) u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (mul_v[g]),
      .ready_o (mul_rdy[g]),
      .a_i     (mul_a[g]),
      .b_i     (s_num),
      .tag_i   (mul_tag[g]),
      .valid_o (pm_v[g][0]),
      .ready_i (pm_r[g][0]),
      .prod_o  (mul_p[g]),
      .tag_o   (mul_tago[g])
    );

    assign pm_rem[g][0] = mul_p[g][CB+SB-1:SB];
    assign pm_num[g][0] = mul_p[g][SB-1:0];
    assign pm_quo[g][0] = '0;
    assign pm_tag[g][0] = mul_tago[g];

    for (genvar c = 0; c < SB; c++) begin : g_cell
      ecc_div_cell #(
        .DW (CB),
        .NW (SB),
        .QW (SB),
        .TW (PTW)
      ) u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (pm_v[g][c]),
        .ready_o (pm_r[g][c]),
        .rem_i   (pm_rem[g][c]),
        .num_i   (pm_num[g][c]),
        .quo_i   (pm_quo[g][c]),
        .tag_i   (pm_tag[g][c]),
        .div_i   (max_iter_q),
        .valid_o (pm_v[g][c+1]),
        .ready_i (pm_r[g][c+1]),
        .rem_o   (pm_rem[g][c+1]),
        .num_o   (pm_num[g][c+1]),
        .quo_o   (pm_quo[g][c+1]),
        .tag_o   (pm_tag[g][c+1])
      );
    end
  end

  // smooth ramp row: color index, then ramp segment and level
  logic           sm_in_valid;
  logic           sm_mul_rdy;
  logic [SPW-1:0] sm_p;
  logic           sm_black;
  logic           sa_v   [QB+1];
  logic           sa_r   [QB+1];
  logic [CB-1:0]  sa_rem [QB+1];
  logic [QB-1:0]  sa_num [QB+1];
  logic [QB-1:0]  sa_quo [QB+1];
  logic           sa_tag [QB+1];
  logic           sb_v   [4];
  logic           sb_r   [4];
  logic [SB-1:0]  sb_rem [4];
  logic [2:0]     sb_num [4];
  logic [2:0]     sb_quo [4];
  logic [1:0]     sb_tag [4];
  logic [QB-1:0]  ramp_idx;
  logic [QB-1:0]  ramp_pos;
  logic [QB-1:0]  ramp_pm1;

  assign sm_in_valid = in_valid_i && table_kind_q;

  ecc_mul_cell #(
    .AW (CB),
    .BW (QB),
    .TW (1)
  ) u_sm_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sm_in_valid),
    .ready_o (sm_mul_rdy),
    .a_i     (iteration_count_i),
    .b_i     (ramp_len),
    .tag_i   (in_black),
    .valid_o (sa_v[0]),
    .ready_i (sa_r[0]),
    .prod_o  (sm_p),
    .tag_o   (sm_black)
  );

  assign sa_rem[0] = sm_p[SPW-1:QB];
  assign sa_num[0] = sm_p[QB-1:0];
  assign sa_quo[0] = '0;
  assign sa_tag[0] = sm_black;

  for (genvar c = 0; c < QB; c++) begin : g_sa
    ecc_div_cell #(
      .DW (CB),
      .NW (QB),
      .QW (QB),
      .TW (1)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sa_v[c]),
      .ready_o (sa_r[c]),
      .rem_i   (sa_rem[c]),
      .num_i   (sa_num[c]),
      .quo_i   (sa_quo[c]),
      .tag_i   (sa_tag[c]),
      .div_i   (max_iter_q),
      .valid_o (sa_v[c+1]),
      .ready_i (sa_r[c+1]),
      .rem_o   (sa_rem[c+1]),
      .num_o   (sa_num[c+1]),
      .quo_o   (sa_quo[c+1]),
      .tag_o   (sa_tag[c+1])
    );
  end

  assign ramp_idx = sa_quo[QB];
  assign ramp_pos = reverse_order_q ? ramp_last - ramp_idx : ramp_idx;
  assign ramp_pm1 = ramp_pos - QB'(1);

  assign sb_v[0]   = sa_v[QB];
  assign sa_r[QB]  = sb_r[0];
  assign sb_rem[0] = ramp_pm1[QB-1:3];
  assign sb_num[0] = ramp_pm1[2:0];
  assign sb_quo[0] = '0;
  assign sb_tag[0] = {sa_tag[QB], ramp_pos == '0};

  for (genvar c = 0; c < 3; c++) begin : g_sb
    ecc_div_cell #(
      .DW (SB),
      .NW (3),
      .QW (3),
      .TW (2)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sb_v[c]),
      .ready_o (sb_r[c]),
      .rem_i   (sb_rem[c]),
      .num_i   (sb_num[c]),
      .quo_i   (sb_quo[c]),
      .tag_i   (sb_tag[c]),
      .div_i   (s_max),
      .valid_o (sb_v[c+1]),
      .ready_i (sb_r[c+1]),
      .rem_o   (sb_rem[c+1]),
      .num_o   (sb_num[c+1]),
      .quo_o   (sb_quo[c+1]),
      .tag_o   (sb_tag[c+1])
    );
  end

  // output side: only the row of the selected palette carries words
  logic col_valid;
  logic col_ready;
  logic col_black;

  assign in_ready_o    = table_kind_q ? sm_mul_rdy : mul_rdy[0];
  assign col_valid     = table_kind_q ? sb_v[3] : pm_v[2][SB];
  assign col_black     = table_kind_q ? sb_tag[3][1] : pm_tag[2][SB][PTW-1];
  assign pm_r[2][SB]   = table_kind_q || col_ready;
  assign sb_r[3]       = !table_kind_q || col_ready;

  ecc_color_cell #(
    .SHADE_BITS (SB)
  ) u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (col_valid),
    .ready_o (col_ready),
    .cfg_i   (cfg),
    .s_max_i (s_max),
    .black_i (col_black),
    .zero_i  (sb_tag[3][0]),
    .d1_i    (pm_tag[2][SB][2*SB-1:SB]),
    .d2_i    (pm_tag[2][SB][SB-1:0]),
    .d3_i    (pm_quo[2][SB]),
    .seg_i   (sb_quo[3]),
    .rem_i   (sb_rem[3]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ecc_mul_cell.sv =====
// escape count color mapper: multiply cell, one registered product per word
// uses ecc_pkg; instantiated by escape_count_color_mapper
`default_nettype none

module ecc_mul_cell
  import ecc_pkg::*;
#(
  parameter int AW = COUNT_BITS_DEF,
  parameter int BW = SHADE_BITS_DEF + 1,
  parameter int TW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  input  wire logic [TW-1:0]    tag_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [AW+BW-1:0]      prod_o,
  output logic [TW-1:0]         tag_o
);

  logic              valid_q;
  logic [AW+BW-1:0]  prod_q, prod_d;
  logic [TW-1:0]     tag_q;

  assign ready_o = !valid_q || ready_i;
  assign prod_d  = (AW+BW)'(a_i) * (AW+BW)'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

// ===== rtl/ecc_div_cell.sv =====
// escape count color mapper: restoring division cell, one quotient bit per word
// uses ecc_pkg; instantiated by escape_count_color_mapper
`default_nettype none

module ecc_div_cell
  import ecc_pkg::*;
#(
  parameter int DW = COUNT_BITS_DEF,
  parameter int NW = SHADE_BITS_DEF,
  parameter int QW = SHADE_BITS_DEF,
  parameter int TW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [QW-1:0] quo_i,
  input  wire logic [TW-1:0] tag_i,
  input  wire logic [DW-1:0] div_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic [DW-1:0]      rem_o,
  output logic [NW-1:0]      num_o,
  output logic [QW-1:0]      quo_o,
  output logic [TW-1:0]      tag_o
);

  logic          valid_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] num_q, num_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [TW-1:0] tag_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;
  logic [QW:0]   quo_ext;

  assign ready_o = !valid_q || ready_i;

  assign trial   = {rem_i, num_i[NW-1]};
  assign diff    = trial - {1'b0, div_i};
  assign take    = trial >= {1'b0, div_i};
  assign rem_d   = take ? diff[DW-1:0] : trial[DW-1:0];
  assign num_d   = num_i << 1;
  assign quo_ext = {quo_i, take};
  assign quo_d   = quo_ext[QW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      quo_q <= quo_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

// ===== rtl/ecc_color_cell.sv =====
// escape count color mapper: palette entry, channel order and output register
// uses ecc_pkg; instantiated by escape_count_color_mapper
`default_nettype none

module ecc_color_cell
  import ecc_pkg::*;
#(
  parameter int SHADE_BITS = SHADE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire pal_cfg_t              cfg_i,
  input  wire logic [SHADE_BITS-1:0] s_max_i,
  input  wire logic                  black_i,
  input  wire logic                  zero_i,
  input  wire logic [SHADE_BITS-1:0] d1_i,
  input  wire logic [SHADE_BITS-1:0] d2_i,
  input  wire logic [SHADE_BITS-1:0] d3_i,
  input  wire logic [2:0]            seg_i,
  input  wire logic [SHADE_BITS-1:0] rem_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o
);

  localparam int SB = SHADE_BITS;

  logic          valid_q;
  logic [7:0]    red_q, red_d;
  logic [7:0]    green_q, green_d;
  logic [7:0]    blue_q, blue_d;
  logic [SB-1:0] ax0, ax1, ax2;
  logic [SB-1:0] lvl;

  assign ready_o = !valid_q || ready_i;
  assign lvl     = rem_i + SB'(1);

  always_comb begin
    ax0 = '0;
    ax1 = '0;
    ax2 = '0;
    if (black_i) begin
      ax0 = '0;
    end else if (!cfg_i.kind) begin
      ax0 = cfg_i.rev ? s_max_i - d1_i : d1_i;
      ax1 = cfg_i.rev ? s_max_i - d2_i : d2_i;
      ax2 = cfg_i.rev ? s_max_i - d3_i : d3_i;
    end else if (!zero_i) begin
      unique case (seg_i)
        3'd0: begin
          ax2 = lvl;
        end
        3'd1: begin
          ax1 = lvl;
          ax2 = s_max_i;
        end
        3'd2: begin
          ax1 = s_max_i;
          ax2 = s_max_i - lvl;
        end
        3'd3: begin
          ax0 = lvl;
          ax1 = s_max_i;
        end
        3'd4: begin
          ax0 = s_max_i;
          ax1 = s_max_i - lvl;
        end
        3'd5: begin
          ax0 = s_max_i;
          ax2 = lvl;
        end
        default: begin
          ax0 = s_max_i;
          ax1 = lvl;
          ax2 = s_max_i;
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_i.ord)
      ORD_RBG: begin
        red_d = 8'(ax0); blue_d = 8'(ax1); green_d = 8'(ax2);
      end
      ORD_GRB: begin
        green_d = 8'(ax0); red_d = 8'(ax1); blue_d = 8'(ax2);
      end
      ORD_GBR: begin
        green_d = 8'(ax0); blue_d = 8'(ax1); red_d = 8'(ax2);
      end
      ORD_BRG: begin
        blue_d = 8'(ax0); red_d = 8'(ax1); green_d = 8'(ax2);
      end
      ORD_BGR: begin
        blue_d = 8'(ax0); green_d = 8'(ax1); red_d = 8'(ax2);
      end
      default: begin
        red_d = 8'(ax0); green_d = 8'(ax1); blue_d = 8'(ax2);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire
